// ----- rtl/bcs_pkg.sv -----
// Shared types and constants of the beep code sequencer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package bcs_pkg;

  // command codes carried in the input item's tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_HIGH_DIV   = 3'd0;
  localparam logic [2:0] REG_LOW_DIV    = 3'd1;
  localparam logic [2:0] REG_SHORT_TONE = 3'd2;
  localparam logic [2:0] REG_SHORT_PAUSE = 3'd3;
  localparam logic [2:0] REG_LONG_TONE  = 3'd4;
  localparam logic [2:0] REG_LONG_PAUSE = 3'd5;
  localparam logic [2:0] REG_CHECK_GAP  = 3'd6;
  localparam logic [2:0] REG_ERROR_GAP  = 3'd7;

  // reset values of the configuration registers
  localparam logic [15:0] HIGH_DIV_RST    = 16'd1193;
  localparam logic [15:0] LOW_DIV_RST     = 16'd1988;
  localparam logic [19:0] SHORT_TONE_RST  = 20'd120000;
  localparam logic [19:0] SHORT_PAUSE_RST = 20'd120000;
  localparam logic [19:0] LONG_TONE_RST   = 20'd700000;
  localparam logic [19:0] LONG_PAUSE_RST  = 20'd350000;
  localparam logic [19:0] CHECK_GAP_RST   = 20'd400000;
  localparam logic [19:0] ERROR_GAP_RST   = 20'd900000;

  // repetitions of the error pattern
  localparam logic [2:0] PATTERN_REPEATS = 3'd3;

  typedef struct packed {
    logic [15:0] high_tone_divisor;
    logic [15:0] low_tone_divisor;
    logic [19:0] short_tone_us;
    logic [19:0] short_pause_us;
    logic [19:0] long_tone_us;
    logic [19:0] long_pause_us;
    logic [19:0] checkpoint_gap_us;
    logic [19:0] error_gap_us;
  } bcs_cfg_t;

  // speaker_on sits in the lowest bit
  typedef struct packed {
    logic        busy_res;
    logic [15:0] tone_divisor;
    logic        speaker_on;
  } bcs_result_t;

  typedef struct packed {
    logic busy;
    logic time_zero;
  } bcs_status_t;

endpackage

`default_nettype wire

// ----- rtl/bcs_regs.sv -----
// Configuration register file of the beep code sequencer.
// Depends on bcs_pkg for the register indexes, reset values and bcs_cfg_t.
`default_nettype none

module bcs_regs
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata,
  output bcs_cfg_t         cfg
);

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_tone_divisor <= HIGH_DIV_RST;
      cfg.low_tone_divisor  <= LOW_DIV_RST;
      cfg.short_tone_us     <= SHORT_TONE_RST;
      cfg.short_pause_us    <= SHORT_PAUSE_RST;
      cfg.long_tone_us      <= LONG_TONE_RST;
      cfg.long_pause_us     <= LONG_PAUSE_RST;
      cfg.checkpoint_gap_us <= CHECK_GAP_RST;
      cfg.error_gap_us      <= ERROR_GAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HIGH_DIV:    cfg.high_tone_divisor <= cfg_wdata[15:0];
        REG_LOW_DIV:     cfg.low_tone_divisor  <= cfg_wdata[15:0];
        REG_SHORT_TONE:  cfg.short_tone_us     <= cfg_wdata;
        REG_SHORT_PAUSE: cfg.short_pause_us    <= cfg_wdata;
        REG_LONG_TONE:   cfg.long_tone_us      <= cfg_wdata;
        REG_LONG_PAUSE:  cfg.long_pause_us     <= cfg_wdata;
        REG_CHECK_GAP:   cfg.checkpoint_gap_us <= cfg_wdata;
        REG_ERROR_GAP:   cfg.error_gap_us      <= cfg_wdata;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bcs_core.sv -----
// Input register, pattern state and phase resolution of the beep code sequencer.
// Depends on bcs_pkg; the result goes to bcs_out_buf.
`default_nettype none

module bcs_core
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire bcs_cfg_t    cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  count,
  input  wire logic        buf_ready,
  output logic             res_valid,
  output bcs_result_t      res,
  output bcs_status_t      status
);

  typedef enum logic [5:0] {
    PH_IDLE        = 6'b000001,
    PH_LONG_TONE   = 6'b000010,
    PH_LONG_PAUSE  = 6'b000100,
    PH_SHORT_TONE  = 6'b001000,
    PH_SHORT_PAUSE = 6'b010000,
    PH_GAP         = 6'b100000
  } phase_t;

  // where phase resolution starts
  typedef enum logic [2:0] {
    ENT_LT, ENT_LP, ENT_SP, ENT_TONES, ENT_GAP, ENT_REPEAT
  } entry_t;

  typedef struct packed {
    phase_t      ph;
    logic [19:0] time_left;
    logic [7:0]  tones;
    logic [2:0]  reps;
  } land_t;

  // walks past phases of zero length to the first one that lasts; a second
  // pass covers one repetition of the error pattern, after which an all-zero
  // repetition can only end in idle
  function automatic land_t resolve(input entry_t ent, input logic [7:0] n_in,
                                    input logic [2:0] r_in, input logic err,
                                    input logic [7:0] saved, input bcs_cfg_t c);
    land_t       lnd;
    entry_t      pos;
    logic [7:0]  n;
    logic [2:0]  r;
    logic [19:0] gap_len;
    logic        done;
    lnd     = '{PH_IDLE, 20'd0, n_in, 3'd0};
    pos     = ent;
    n       = n_in;
    r       = r_in;
    done    = 1'b0;
    gap_len = err ? c.error_gap_us : c.checkpoint_gap_us;
    for (int pass = 0; pass < 2; pass++) begin
      if (!done && pos == ENT_LT) begin
        if (c.long_tone_us != 20'd0) begin
          lnd  = '{PH_LONG_TONE, c.long_tone_us, n, r};
          done = 1'b1;
        end else pos = ENT_LP;
      end
      if (!done && pos == ENT_LP) begin
        if (c.long_pause_us != 20'd0) begin
          lnd  = '{PH_LONG_PAUSE, c.long_pause_us, n, r};
          done = 1'b1;
        end else pos = ENT_TONES;
      end
      if (!done && pos == ENT_SP) begin
        if (c.short_pause_us != 20'd0) begin
          lnd  = '{PH_SHORT_PAUSE, c.short_pause_us, n, r};
          done = 1'b1;
        end else pos = ENT_TONES;
      end
      if (!done && pos == ENT_TONES) begin
        if (n != 8'd0) begin
          if (c.short_tone_us != 20'd0) begin
            lnd  = '{PH_SHORT_TONE, c.short_tone_us, n - 8'd1, r};
            done = 1'b1;
          end else if (c.short_pause_us != 20'd0) begin
            lnd  = '{PH_SHORT_PAUSE, c.short_pause_us, n - 8'd1, r};
            done = 1'b1;
          end else begin
            // all tones of zero length go by at once
            n   = 8'd0;
            pos = ENT_GAP;
          end
        end else pos = ENT_GAP;
      end
      if (!done && pos == ENT_GAP) begin
        if (gap_len != 20'd0) begin
          lnd  = '{PH_GAP, gap_len, n, r};
          done = 1'b1;
        end else pos = ENT_REPEAT;
      end
      if (!done && pos == ENT_REPEAT) begin
        if (err && r > 3'd1) begin
          r   = r - 3'd1;
          n   = saved;
          pos = ENT_LT;
        end else begin
          lnd  = '{PH_IDLE, 20'd0, n, 3'd0};
          done = 1'b1;
        end
      end
    end
    if (!done) lnd = '{PH_IDLE, 20'd0, n, 3'd0};
    return lnd;
  endfunction

  // speaker gate, divisor and busy for a phase
  function automatic bcs_result_t report(input phase_t ph, input logic [7:0] saved,
                                         input logic err, input bcs_cfg_t c);
    bcs_result_t o;
    o.speaker_on   = 1'b0;
    o.tone_divisor = 16'd0;
    o.busy_res     = (ph != PH_IDLE);
    unique case (ph)
      PH_LONG_TONE: begin
        o.speaker_on   = 1'b1;
        o.tone_divisor = c.low_tone_divisor;
      end
      PH_LONG_PAUSE: o.tone_divisor = c.low_tone_divisor;
      PH_SHORT_TONE: begin
        o.speaker_on   = 1'b1;
        o.tone_divisor = c.high_tone_divisor;
      end
      PH_SHORT_PAUSE: o.tone_divisor = c.high_tone_divisor;
      PH_GAP: begin
        if (saved != 8'd0) o.tone_divisor = c.high_tone_divisor;
        else if (err) o.tone_divisor = c.low_tone_divisor;
      end
      default: ;
    endcase
    return o;
  endfunction

  logic        in_full;
  logic [1:0]  in_cmd;
  logic [7:0]  in_count;

  phase_t      phase, phase_next;
  logic [19:0] time_left, time_left_next;
  logic [7:0]  tones_left, tones_left_next;
  logic [2:0]  repeats_left, repeats_left_next;
  logic [7:0]  saved_count, saved_count_next;
  logic        error_mode, error_mode_next;

  logic        proc;
  logic [19:0] time_dec;
  entry_t      tick_ent;
  entry_t      start_ent;
  logic        start_err;
  logic [2:0]  start_reps;
  land_t       tick_land;
  land_t       start_land;

  // input register; an item is worked on once the result buffer has room
  assign in_ready = !in_full || buf_ready;
  assign proc     = in_full && buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd   <= cmd;
      in_count <= count;
    end
  end

  // what follows the phase now running
  always_comb begin
    unique case (phase)
      PH_LONG_TONE:   tick_ent = ENT_LP;
      PH_LONG_PAUSE:  tick_ent = ENT_TONES;
      PH_SHORT_TONE:  tick_ent = ENT_SP;
      PH_SHORT_PAUSE: tick_ent = ENT_TONES;
      default:        tick_ent = ENT_REPEAT;
    endcase
  end

  assign time_dec   = time_left - 20'd1;
  assign start_err  = (in_cmd == CMD_ERROR);
  assign start_ent  = start_err ? ENT_LT : ENT_TONES;
  assign start_reps = start_err ? PATTERN_REPEATS : 3'd0;
  assign tick_land  = resolve(tick_ent, tones_left, repeats_left, error_mode,
                              saved_count, cfg);
  assign start_land = resolve(start_ent, in_count, start_reps, start_err, in_count, cfg);

  // next state and result of the item in the input register
  always_comb begin
    phase_next        = phase;
    time_left_next    = time_left;
    tones_left_next   = tones_left;
    repeats_left_next = repeats_left;
    saved_count_next  = saved_count;
    error_mode_next   = error_mode;
    res               = report(phase, saved_count, error_mode, cfg);
    if (proc) begin
      case (in_cmd) inside
        CMD_TICK: begin
          if (phase != PH_IDLE) begin
            if (time_dec != 20'd0) begin
              time_left_next = time_dec;
            end else begin
              phase_next        = tick_land.ph;
              time_left_next    = tick_land.time_left;
              tones_left_next   = tick_land.tones;
              repeats_left_next = tick_land.reps;
            end
          end
        end
        CMD_CHECK, CMD_ERROR: begin
          if (phase == PH_IDLE) begin
            phase_next        = start_land.ph;
            time_left_next    = start_land.time_left;
            tones_left_next   = start_land.tones;
            repeats_left_next = start_land.reps;
            saved_count_next  = in_count;
            error_mode_next   = start_err;
            res               = report(start_land.ph, in_count, start_err, cfg);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      time_left    <= 20'd0;
      tones_left   <= 8'd0;
      repeats_left <= 3'd0;
      saved_count  <= 8'd0;
      error_mode   <= 1'b0;
    end else begin
      phase        <= phase_next;
      time_left    <= time_left_next;
      tones_left   <= tones_left_next;
      repeats_left <= repeats_left_next;
      saved_count  <= saved_count_next;
      error_mode   <= error_mode_next;
    end
  end

  assign res_valid        = proc;
  assign status.busy      = (phase != PH_IDLE);
  assign status.time_zero = (time_left == 20'd0);

endmodule

`default_nettype wire

// ----- rtl/bcs_out_buf.sv -----
// Result register with a skid entry for the beep code sequencer output.
// Depends on bcs_pkg for bcs_result_t.
`default_nettype none

module bcs_out_buf
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire bcs_result_t push_data,
  output logic             buf_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bcs_result_t      out_data
);

  logic        skid_valid;
  bcs_result_t skid_data;

  assign buf_ready = !skid_valid;

  // control: main register refills from the skid entry first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) out_data <= skid_data;
      else if (push) out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/beep_code_sequencer.sv -----
// Top level of the beep code sequencer: register file, core and result buffer.
// Depends on bcs_pkg, bcs_regs, bcs_core and bcs_out_buf.
//
//   channel   direction  handshake                  payload
//   s_*       in         s_tvalid / s_tready        tuser cmd, tdata count
//   m_*       out        m_tvalid / m_tready        tdata speaker_on, tone_divisor, busy_res
//   cfg_*     in         cfg_wr_en, no wait         cfg_index, cfg_wdata
//
// One item per cycle sustained while the skid entry has room; each item is held in
// the input register and then moves to the result register or the skid entry. All
// zero-length phases of a start or tick are resolved combinationally as the item
// leaves the input register. rst is synchronous and clears control state and loads
// register defaults.
// A stalled output is absorbed by one skid entry; s_tready drops only when the
// skid entry is full and the input register still holds an item.
`default_nettype none

module beep_code_sequencer
  import bcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] count
  input  wire logic [1:0]  s_tuser,   // [1:0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [0] speaker_on, [16:1] tone_divisor, [17] busy_res
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_wdata
);

  bcs_cfg_t    cfg;
  bcs_result_t res;
  bcs_result_t out_data;
  bcs_status_t status;
  logic        res_valid;
  logic        buf_ready;

  bcs_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (s_tuser),
    .count     (s_tdata),
    .buf_ready (buf_ready),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  bcs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .buf_ready (buf_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {6'd0, out_data};

  // a running phase always has time left
  assert property (@(posedge clk) disable iff (rst) status.busy |-> !status.time_zero)
    else $error("running phase with no time left");

  // the skid entry only fills behind a held result
  assert property (@(posedge clk) disable iff (rst) !buf_ready |-> m_tvalid)
    else $error("skid entry full with empty result register");

  // a tone only sounds while a pattern plays
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tdata[0]) |-> m_tdata[17])
    else $error("speaker on while idle");

  // idle selects no divisor
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[17]) |-> (m_tdata[16:1] == 16'd0))
    else $error("divisor selected while idle");

endmodule

`default_nettype wire
